// ===== hdl/dtq_pkg.sv =====
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int DL_W   = 63;
  localparam int PER_W  = 40;
  localparam int TAG_W  = 32;
  localparam int MIND_W = 20;
  localparam logic [MIND_W-1:0] MIN_DELAY_RST = 20'd100;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] RK_ADDED     = 3'd0;
  localparam logic [2:0] RK_FULL      = 3'd1;
  localparam logic [2:0] RK_CANCELLED = 3'd2;
  localparam logic [2:0] RK_NOT_FOUND = 3'd3;
  localparam logic [2:0] RK_EXPIRED   = 3'd4;
  localparam logic [2:0] RK_NONE      = 3'd5;

  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [PER_W-1:0] period;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

// ===== hdl/deadline_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// Timer queue with periodic re-arm over TIMER_SLOTS slots.
// Input channel in_*: one transaction per command (add, cancel, expire check).
// Result channel out_*: add and cancel give one result, an expire check gives
// one result per expired timer (last_result on the final one) or a single
// "none expired" result. Operation code 3 is taken and gives no result.
// Config channel cfg_*: min_arm_delay, always ready; it is to be written only
// while idle, which the block itself does not enforce. The slot records live
// in one synchronous memory; every command but operation code 3 sweeps it
// with a scan. An expire check scans once per timer that it finds and once
// more, then gives one result at a time while the receiver is ready.
// One command is handled at a time; in_ready is high only while idle.
// Results sit in an output register until out_ready; a stalled receiver
// holds the block in place with nothing lost.
// Reset (synchronous, rst_n low) frees all slots, clears the tag counter and
// sets min_arm_delay to 100.
module deadline_timer_queue_unit
  import dtq_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [DL_W-1:0]   in_when_time,
  input  logic [PER_W-1:0]  in_interval_us,
  input  logic [3:0]        in_cancel_slot,
  input  logic [TAG_W-1:0]  in_cancel_tag,
  input  logic [DL_W-1:0]   in_now_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_result_kind,
  output logic [3:0]        out_handle_slot,
  output logic [TAG_W-1:0]  out_handle_tag,
  output logic              out_earliest_changed,
  output logic              out_next_valid,
  output logic [DL_W-1:0]   out_next_deadline,
  output logic [DL_W-1:0]   out_arm_delay,
  output logic              out_last_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MIND_W-1:0] cfg_min_arm_delay
);

  localparam int AW = $clog2(TIMER_SLOTS);
  localparam int CW = ((AW > 4) ? AW : 4) + 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_DRAIN  = 9'b000000100,
    S_SETTLE = 9'b000001000,
    S_POST   = 9'b000010000,
    S_CAN_RD = 9'b000100000,
    S_CAN_CK = 9'b001000000,
    S_EMIT   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [MIND_W-1:0] mind_r;
  logic [TIMER_SLOTS-1:0] busy_r;
  logic [TIMER_SLOTS-1:0] taken_r;
  logic [TAG_W-1:0] tagc_r;
  logic [1:0]       op_r;
  logic [DL_W-1:0]  when_r, now_r;
  logic [PER_W-1:0] per_r;
  logic [3:0]       cslot_r;
  logic [TAG_W-1:0] ctag_r;
  logic             hit_r;
  logic [AW-1:0]    addr_r;
  logic             rd_vld_r, rd_busy_r, rd_elig_r;
  logic [AW-1:0]    rd_slot_r;
  logic [AW-1:0]    order_r [TIMER_SLOTS];
  logic [AW:0]      n_r;
  logic [AW-1:0]    k_r;
  logic             nv_r;
  logic [DL_W-1:0]  nd_r;
  logic             emit_d_r;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;
  logic             scan_clr;
  logic             any_s, found_s;
  logic [DL_W-1:0]  min_s;
  logic [AW-1:0]    pick_s;
  entry_t           pent_s;

  logic             free_any;
  logic [AW-1:0]    free_idx;
  logic [CW-1:0]    cext;
  logic [AW-1:0]    cidx;
  logic             cin_range;
  logic [DL_W:0]    rearm_sum;
  logic [DL_W-1:0]  rearm_dl;
  logic             add_chg;

  function automatic logic [DL_W-1:0] arm_delay_f(input logic v, input logic [DL_W-1:0] dl,
                                                   input logic [DL_W-1:0] now,
                                                   input logic [MIND_W-1:0] md);
    logic [DL_W-1:0] d;
    begin
      d = (dl > now) ? (dl - now) : '0;
      if (!v) begin
        d = '0;
      end else if (d < {{(DL_W-MIND_W){1'b0}}, md}) begin
        d = {{(DL_W-MIND_W){1'b0}}, md};
      end
      return d;
    end
  endfunction

  dtq_slot_mem #(.DEPTH(TIMER_SLOTS), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  dtq_scan_unit #(.AW(AW)) u_scan (
    .clk(clk), .rst_n(rst_n), .clr(scan_clr), .vld(rd_vld_r), .slot(rd_slot_r),
    .busy(rd_busy_r), .elig(rd_elig_r), .ent(mem_rdata), .now(now_r), .any_o(any_s),
    .min_dl_o(min_s), .found_o(found_s), .pick_slot_o(pick_s), .pick_ent_o(pent_s)
  );

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  assign cext      = CW'(cslot_r);
  assign cin_range = (cext < CW'(TIMER_SLOTS));
  assign cidx      = cext[AW-1:0];
  assign rearm_sum = {1'b0, now_r} + {{(DL_W+1-PER_W){1'b0}}, pent_s.period};
  assign rearm_dl  = rearm_sum[DL_W] ? {DL_W{1'b1}} : rearm_sum[DL_W-1:0];
  assign add_chg   = !any_s || (when_r < min_s);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_clr  = (state_r == S_IDLE) || (state_r == S_CAN_CK) ||
                     (state_r == S_POST && op_r == OP_EXPIRE && found_s);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = '{deadline: when_r, period: per_r, tag: tagc_r};
    mem_raddr = addr_r;
    if (state_r == S_CAN_RD) begin
      mem_raddr = cidx;
    end else if (state_r == S_EMIT) begin
      mem_raddr = order_r[k_r];
    end
    if (state_r == S_POST) begin
      if (op_r == OP_ADD && free_any) begin
        mem_we = 1'b1;
      end else if (op_r == OP_EXPIRE && found_s && pent_s.period != '0) begin
        mem_we    = 1'b1;
        mem_waddr = pick_s;
        mem_wdata = '{deadline: rearm_dl, period: pent_s.period, tag: pent_s.tag};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_operation != OP_UNUSED) begin
          state_nxt = (in_operation == OP_CANCEL) ? S_CAN_RD : S_SCAN;
        end
      end
      S_SCAN:   state_nxt = (addr_r == AW'(TIMER_SLOTS - 1)) ? S_DRAIN : S_SCAN;
      S_DRAIN:  state_nxt = S_SETTLE;
      S_SETTLE: state_nxt = S_POST;
      S_POST: begin
        if (op_r == OP_EXPIRE && found_s) begin
          state_nxt = S_SCAN;
        end else if (op_r == OP_EXPIRE && n_r != '0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_CAN_RD: state_nxt = S_CAN_CK;
      S_CAN_CK: state_nxt = S_SCAN;
      S_EMIT:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_valid && out_ready) begin
          state_nxt = (op_r == OP_EXPIRE && !out_last_result) ? S_EMIT : S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mind_r    <= MIN_DELAY_RST;
      busy_r    <= '0;
      taken_r   <= '0;
      tagc_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_valid <= 1'b0;
      addr_r    <= '0;
      n_r       <= '0;
      k_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_SCAN);
      if (cfg_valid) begin
        mind_r <= cfg_min_arm_delay;
      end
      if (state_r == S_SCAN) begin
        addr_r <= addr_r + 1'b1;
      end else begin
        addr_r <= '0;
      end
      if (state_r == S_IDLE) begin
        n_r     <= '0;
        k_r     <= '0;
        taken_r <= '0;
      end
      if (state_r == S_CAN_CK && cin_range && busy_r[cidx] && mem_rdata.tag == ctag_r) begin
        busy_r[cidx] <= 1'b0;
      end
      if (state_r == S_POST) begin
        if (op_r == OP_ADD && free_any) begin
          busy_r[free_idx] <= 1'b1;
          tagc_r           <= tagc_r + 1'b1;
        end
        if (op_r == OP_EXPIRE && found_s) begin
          n_r             <= n_r + 1'b1;
          taken_r[pick_s] <= 1'b1;
          if (pent_s.period == '0) begin
            busy_r[pick_s] <= 1'b0;
          end
        end
        if (!(op_r == OP_EXPIRE && (found_s || n_r != '0))) begin
          out_valid <= 1'b1;
        end
      end
      // An expired entry is shown once its tag has come back from memory.
      if (emit_d_r) begin
        out_valid <= 1'b1;
      end
      if (state_r == S_OUT && out_valid && out_ready) begin
        out_valid <= 1'b0;
        k_r       <= k_r + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      op_r    <= in_operation;
      when_r  <= in_when_time;
      per_r   <= in_interval_us;
      cslot_r <= in_cancel_slot;
      ctag_r  <= in_cancel_tag;
      now_r   <= in_now_time;
    end
    if (state_r == S_SCAN) begin
      rd_slot_r <= addr_r;
      rd_busy_r <= busy_r[addr_r];
      rd_elig_r <= busy_r[addr_r] && !taken_r[addr_r];
    end
    if (state_r == S_CAN_CK) begin
      hit_r <= cin_range && busy_r[cidx] && (mem_rdata.tag == ctag_r);
    end
    if (state_r == S_POST) begin
      out_handle_slot      <= '0;
      out_handle_tag       <= '0;
      out_earliest_changed <= 1'b0;
      out_last_result      <= 1'b1;
      out_next_valid       <= any_s;
      out_next_deadline    <= any_s ? min_s : '0;
      out_arm_delay        <= arm_delay_f(any_s, min_s, now_r, mind_r);
      nv_r                 <= any_s;
      nd_r                 <= any_s ? min_s : '0;
      if (op_r == OP_EXPIRE && found_s) begin
        order_r[n_r[AW-1:0]] <= pick_s;
      end
      case (op_r)
        OP_ADD: begin
          if (free_any) begin
            out_result_kind      <= RK_ADDED;
            out_handle_slot      <= 4'(free_idx);
            out_handle_tag       <= tagc_r;
            out_earliest_changed <= add_chg;
            out_next_valid       <= 1'b1;
            out_next_deadline    <= add_chg ? when_r : min_s;
            out_arm_delay        <= arm_delay_f(1'b1, add_chg ? when_r : min_s, now_r, mind_r);
          end else begin
            out_result_kind <= RK_FULL;
          end
        end
        OP_CANCEL: out_result_kind <= hit_r ? RK_CANCELLED : RK_NOT_FOUND;
        default:   out_result_kind <= RK_NONE;
      endcase
    end
    if (state_r == S_EMIT) begin
      out_result_kind      <= RK_EXPIRED;
      out_handle_slot      <= 4'(order_r[k_r]);
      out_earliest_changed <= 1'b0;
      out_last_result      <= ({1'b0, k_r} + 1'b1 == n_r);
      out_next_valid       <= nv_r;
      out_next_deadline    <= nd_r;
      out_arm_delay        <= arm_delay_f(nv_r, nd_r, now_r, mind_r);
    end
    if (emit_d_r) begin
      out_handle_tag <= mem_rdata.tag;
    end
  end

  // The tag arrives from memory in the cycle after the emit read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_d_r <= 1'b0;
    end else begin
      emit_d_r <= (state_r == S_EMIT);
    end
  end

endmodule

// ===== hdl/dtq_slot_mem.sv =====
`timescale 1ns / 1ps
module dtq_slot_mem
  import dtq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dtq_scan_unit.sv =====
`timescale 1ns / 1ps
module dtq_scan_unit
  import dtq_pkg::*;
#(
  parameter int AW = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  logic            vld,
  input  logic [AW-1:0]   slot,
  input  logic            busy,
  input  logic            elig,
  input  entry_t          ent,
  input  logic [DL_W-1:0] now,
  output logic            any_o,
  output logic [DL_W-1:0] min_dl_o,
  output logic            found_o,
  output logic [AW-1:0]   pick_slot_o,
  output entry_t          pick_ent_o
);

  logic            any_r, found_r;
  logic [DL_W-1:0] min_r;
  logic [AW-1:0]   pick_r;
  entry_t          pent_r;

  // Slots arrive in ascending order, so a strict compare keeps ties on the lower slot.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      any_r   <= 1'b0;
      found_r <= 1'b0;
    end else if (vld && busy) begin
      if (!any_r || ent.deadline < min_r) begin
        any_r <= 1'b1;
        min_r <= ent.deadline;
      end
      // Timers already picked by this expire check are no longer candidates.
      if (elig && ent.deadline <= now && (!found_r || ent.deadline < pent_r.deadline)) begin
        found_r <= 1'b1;
        pick_r  <= slot;
        pent_r  <= ent;
      end
    end
  end

  assign any_o       = any_r;
  assign min_dl_o    = min_r;
  assign found_o     = found_r;
  assign pick_slot_o = pick_r;
  assign pick_ent_o  = pent_r;

endmodule

// ===== hdl/dtq_checker.sv =====
`timescale 1ns / 1ps
module dtq_checker
  import dtq_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [2:0]      out_result_kind,
  input logic            out_next_valid,
  input logic [DL_W-1:0] out_next_deadline,
  input logic [DL_W-1:0] out_arm_delay,
  input logic            out_last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind))
    else $error("result transaction dropped or changed while stalled");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("command accepted while a result is pending");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_next_valid |-> out_next_deadline == '0 && out_arm_delay == '0)
    else $error("empty queue reports a deadline");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != RK_EXPIRED |-> out_last_result)
    else $error("single result not marked last");

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_result_kind(out_result_kind),
  .out_next_valid(out_next_valid), .out_next_deadline(out_next_deadline),
  .out_arm_delay(out_arm_delay), .out_last_result(out_last_result)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import dtq_pkg::*;

  localparam int SLOTS = 16;
  localparam int MAX_IDLE = 18;
  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 400;
  localparam int LONG_HOLD = 600;
  localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};
  localparam logic [2:0] RK_ANY = 3'd7;

  typedef struct packed {
    logic [1:0]       op;
    logic [DL_W-1:0]  when_t;
    logic [PER_W-1:0] period;
    logic [3:0]       cslot;
    logic [TAG_W-1:0] ctag;
    logic [DL_W-1:0]  now_t;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [3:0]       slot;
    logic [TAG_W-1:0] tag;
    logic             changed;
    logic             nvalid;
    logic [DL_W-1:0]  ndl;
    logic [DL_W-1:0]  delay;
    logic             last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [DL_W-1:0] in_when_time = '0;
  logic [PER_W-1:0] in_interval_us = '0;
  logic [3:0] in_cancel_slot = '0;
  logic [TAG_W-1:0] in_cancel_tag = '0;
  logic [DL_W-1:0] in_now_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_result_kind;
  logic [3:0] out_handle_slot;
  logic [TAG_W-1:0] out_handle_tag;
  logic out_earliest_changed;
  logic out_next_valid;
  logic [DL_W-1:0] out_next_deadline;
  logic [DL_W-1:0] out_arm_delay;
  logic out_last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MIND_W-1:0] cfg_min_arm_delay = '0;

  deadline_timer_queue_unit #(.TIMER_SLOTS(SLOTS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_when_time(in_when_time), .in_interval_us(in_interval_us),
    .in_cancel_slot(in_cancel_slot), .in_cancel_tag(in_cancel_tag),
    .in_now_time(in_now_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_handle_slot(out_handle_slot), .out_handle_tag(out_handle_tag),
    .out_earliest_changed(out_earliest_changed), .out_next_valid(out_next_valid),
    .out_next_deadline(out_next_deadline), .out_arm_delay(out_arm_delay),
    .out_last_result(out_last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_min_arm_delay(cfg_min_arm_delay)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the timer slots.
  logic             sh_busy [SLOTS];
  logic [DL_W-1:0]  sh_dl   [SLOTS];
  logic [PER_W-1:0] sh_per  [SLOTS];
  logic [TAG_W-1:0] sh_tag  [SLOTS];
  logic [TAG_W-1:0] sh_next_tag;
  logic [MIND_W-1:0] sh_min_delay;

  answer_t pending_answers[$];
  logic [2:0] hint_kinds[$];
  int errors = 0;
  int quiet = 0;

  function automatic answer_t make_answer(logic [2:0] kind, logic [3:0] slot,
                                          logic [TAG_W-1:0] tag, logic changed,
                                          logic [DL_W-1:0] now_t, logic last);
    answer_t a;
    logic any;
    logic [DL_W-1:0] best;
    any = 1'b0;
    best = '0;
    for (int i = 0; i < SLOTS; i++)
      if (sh_busy[i] && (!any || sh_dl[i] < best)) begin
        best = sh_dl[i];
        any = 1'b1;
      end
    a.kind = kind;
    a.slot = slot;
    a.tag = tag;
    a.changed = changed;
    a.nvalid = any;
    a.ndl = any ? best : '0;
    a.delay = '0;
    if (any) begin
      a.delay = (best > now_t) ? best - now_t : '0;
      if (a.delay < DL_W'(sh_min_delay)) a.delay = DL_W'(sh_min_delay);
    end
    a.last = last;
    return a;
  endfunction

  task automatic predict_command(input cmd_t c);
    int free_slot;
    int n;
    int pick;
    int order[SLOTS];
    logic [TAG_W-1:0] tags[SLOTS];
    logic taken[SLOTS];
    logic any;
    logic [DL_W-1:0] best;
    logic earlier;
    free_slot = -1;
    n = 0;
    case (c.op)
      OP_ADD: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!sh_busy[i]) free_slot = i;
        if (free_slot < 0) begin
          pending_answers.push_back(make_answer(RK_FULL, '0, '0, 1'b0, c.now_t, 1'b1));
        end else begin
          any = 1'b0;
          best = '0;
          for (int i = 0; i < SLOTS; i++)
            if (sh_busy[i] && (!any || sh_dl[i] < best)) begin
              best = sh_dl[i];
              any = 1'b1;
            end
          earlier = !any || c.when_t < best;
          sh_busy[free_slot] = 1'b1;
          sh_dl[free_slot] = c.when_t;
          sh_per[free_slot] = c.period;
          sh_tag[free_slot] = sh_next_tag;
          sh_next_tag = sh_next_tag + 1'b1;
          pending_answers.push_back(make_answer(RK_ADDED, 4'(free_slot),
            sh_tag[free_slot], earlier, c.now_t, 1'b1));
        end
      end
      OP_CANCEL: begin
        if (sh_busy[c.cslot] && sh_tag[c.cslot] == c.ctag) begin
          sh_busy[c.cslot] = 1'b0;
          pending_answers.push_back(make_answer(RK_CANCELLED, '0, '0, 1'b0, c.now_t, 1'b1));
        end else begin
          pending_answers.push_back(make_answer(RK_NOT_FOUND, '0, '0, 1'b0, c.now_t, 1'b1));
        end
      end
      OP_EXPIRE: begin
        for (int i = 0; i < SLOTS; i++) taken[i] = 1'b0;
        forever begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (sh_busy[i] && !taken[i] && sh_dl[i] <= c.now_t &&
                (pick < 0 || sh_dl[i] < sh_dl[pick]))
              pick = i;
          if (pick < 0) break;
          taken[pick] = 1'b1;
          tags[n] = sh_tag[pick];
          order[n] = pick;
          n++;
        end
        for (int k = 0; k < n; k++) begin
          if (sh_per[order[k]] != 0)
            sh_dl[order[k]] = (c.now_t > DL_MAX - DL_W'(sh_per[order[k]])) ? DL_MAX :
                              c.now_t + DL_W'(sh_per[order[k]]);
          else
            sh_busy[order[k]] = 1'b0;
        end
        if (n == 0)
          pending_answers.push_back(make_answer(RK_NONE, '0, '0, 1'b0, c.now_t, 1'b1));
        for (int k = 0; k < n; k++)
          pending_answers.push_back(make_answer(RK_EXPIRED, 4'(order[k]), tags[k],
                                                1'b0, c.now_t, k == n - 1));
      end
      default: ;
    endcase
  endtask

  // Result side: checks every transaction, stalls at random.
  int hold_cycles = 0;
  int long_hold = 0;
  bit long_hold_go = 1'b0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $error("unexpected result kind %0d", out_result_kind);
      end else begin
        answer_t e;
        logic [2:0] hint;
        e = pending_answers.pop_front();
        hint = hint_kinds.size() ? hint_kinds.pop_front() : RK_ANY;
        if (hint != RK_ANY && hint != out_result_kind) begin
          errors++;
          $error("result_kind (table) expected %0d got %0d", hint, out_result_kind);
        end
        if (e.kind != out_result_kind) begin
          errors++; $error("result_kind expected %0d got %0d", e.kind, out_result_kind);
        end
        if (e.slot != out_handle_slot) begin
          errors++; $error("handle_slot expected %0d got %0d", e.slot, out_handle_slot);
        end
        if (e.tag != out_handle_tag) begin
          errors++; $error("handle_tag expected %0d got %0d", e.tag, out_handle_tag);
        end
        if (e.changed != out_earliest_changed) begin
          errors++;
          $error("earliest_changed expected %0d got %0d", e.changed, out_earliest_changed);
        end
        if (e.nvalid != out_next_valid) begin
          errors++; $error("next_valid expected %0d got %0d", e.nvalid, out_next_valid);
        end
        if (e.ndl != out_next_deadline) begin
          errors++;
          $error("next_deadline expected %0d got %0d", e.ndl, out_next_deadline);
        end
        if (e.delay != out_arm_delay) begin
          errors++; $error("arm_delay expected %0d got %0d", e.delay, out_arm_delay);
        end
        if (e.last != out_last_result) begin
          errors++;
          $error("last_result expected %0d got %0d", e.last, out_last_result);
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      long_hold <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready || !out_ready && hold_cycles == 0) begin
      hold_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
      out_ready <= (hold_cycles == 0);
    end else if (!out_ready) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= (hold_cycles == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_command(input cmd_t c, input logic [2:0] hint);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= c.op;
    in_when_time <= c.when_t;
    in_interval_us <= c.period;
    in_cancel_slot <= c.cslot;
    in_cancel_tag <= c.ctag;
    in_now_time <= c.now_t;
    do @(posedge clk); while (!in_ready);
    predict_command(c);
    if (c.op != OP_UNUSED) begin
      if (c.op == OP_EXPIRE && hint == RK_ANY) begin
        for (int i = hint_kinds.size(); i < pending_answers.size(); i++)
          hint_kinds.push_back(RK_ANY);
      end else begin
        for (int i = hint_kinds.size(); i < pending_answers.size(); i++)
          hint_kinds.push_back(hint);
      end
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_delay(input logic [MIND_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_min_arm_delay <= v;
    do @(posedge clk); while (!cfg_ready);
    sh_min_delay = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cmd_t build(logic [1:0] op, logic [DL_W-1:0] w, logic [PER_W-1:0] p,
                                 logic [3:0] s, logic [TAG_W-1:0] t, logic [DL_W-1:0] n);
    cmd_t c;
    c.op = op; c.when_t = w; c.period = p; c.cslot = s; c.ctag = t; c.now_t = n;
    return c;
  endfunction

  function automatic logic [DL_W-1:0] rand_time(logic [DL_W-1:0] base);
    case ($urandom_range(0, 5))
      0: return DL_W'({$urandom, $urandom});
      1: return DL_MAX - DL_W'($urandom_range(0, 300));
      2: return '0;
      default: return base + DL_W'($urandom_range(0, 4000));
    endcase
  endfunction

  task automatic random_command(inout logic [DL_W-1:0] clock_t);
    cmd_t c;
    int live[$];
    int r;
    logic [DL_W-1:0] wt;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) clock_t = clock_t + DL_W'($urandom_range(0, 3000));
    c = build(OP_ADD, '0, '0, '0, '0, clock_t);
    if (r < 45) begin
      c.when_t = ($urandom_range(0, 7) == 0) ? rand_time(clock_t)
                                             : clock_t + DL_W'($urandom_range(0, 3000));
      case ($urandom_range(0, 4))
        0: c.period = '0;
        1: c.period = PER_W'({$urandom, $urandom});
        2: c.period = {PER_W{1'b1}};
        default: c.period = PER_W'($urandom_range(1, 2000));
      endcase
    end else if (r < 65) begin
      c.op = OP_CANCEL;
      for (int i = 0; i < SLOTS; i++) if (sh_busy[i]) live.push_back(i);
      if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
        c.cslot = 4'(live[$urandom_range(0, live.size() - 1)]);
        c.ctag = sh_tag[c.cslot];
        if ($urandom_range(0, 5) == 0) c.ctag = c.ctag ^ (32'd1 << $urandom_range(0, 31));
      end else begin
        c.cslot = 4'($urandom_range(0, 15));
        c.ctag = $urandom;
      end
    end else if (r < 97) begin
      c.op = OP_EXPIRE;
      if ($urandom_range(0, 9) == 0) c.now_t = rand_time(clock_t);
    end else begin
      c.op = OP_UNUSED;
      c.when_t = DL_W'({$urandom, $urandom});
      c.period = PER_W'({$urandom, $urandom});
      c.ctag = $urandom;
    end
    wt = c.now_t;
    send_command(c, RK_ANY);
    if (c.op == OP_UNUSED) clock_t = wt;
  endtask

  initial begin : main
    cmd_t rows[$];
    logic [2:0] row_hint[$];
    logic [DL_W-1:0] clock_t;
    int sent;
    for (int i = 0; i < SLOTS; i++) begin
      sh_busy[i] = 1'b0; sh_dl[i] = '0; sh_per[i] = '0; sh_tag[i] = '0;
    end
    sh_next_tag = '0;
    sh_min_delay = MIN_DELAY_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; a kind of RK_ANY is left to the predictor alone.
    rows.push_back(build(OP_EXPIRE, '0, '0, '0, '0, '0));        row_hint.push_back(RK_NONE);
    rows.push_back(build(OP_CANCEL, '0, '0, 4'd0, '0, '0));      row_hint.push_back(RK_NOT_FOUND);
    rows.push_back(build(OP_ADD, 63'd500, 40'd0, '0, '0, 63'd0)); row_hint.push_back(RK_ADDED);
    rows.push_back(build(OP_ADD, 63'd500, 40'd10, '0, '0, 63'd0)); row_hint.push_back(RK_ADDED);
    rows.push_back(build(OP_ADD, DL_MAX, {PER_W{1'b1}}, '0, '0, DL_MAX)); row_hint.push_back(RK_ADDED);
    rows.push_back(build(OP_ADD, 63'd5, 40'd1, '0, '0, 63'd4));  row_hint.push_back(RK_ADDED);
    rows.push_back(build(OP_CANCEL, '0, '0, 4'd0, 32'd1, 63'd0)); row_hint.push_back(RK_NOT_FOUND);
    rows.push_back(build(OP_CANCEL, '0, '0, 4'd0, 32'd0, 63'd0)); row_hint.push_back(RK_CANCELLED);
    rows.push_back(build(OP_CANCEL, '0, '0, 4'd15, '1, 63'd0));  row_hint.push_back(RK_NOT_FOUND);
    rows.push_back(build(OP_UNUSED, '1, '1, '1, '1, '1));        row_hint.push_back(RK_ANY);
    rows.push_back(build(OP_EXPIRE, '0, '0, '0, '0, 63'd499));   row_hint.push_back(RK_EXPIRED);
    rows.push_back(build(OP_EXPIRE, '0, '0, '0, '0, 63'd500));   row_hint.push_back(RK_EXPIRED);
    rows.push_back(build(OP_EXPIRE, '0, '0, '0, '0, DL_MAX - 1)); row_hint.push_back(RK_EXPIRED);
    rows.push_back(build(OP_EXPIRE, '0, '0, '0, '0, DL_MAX));    row_hint.push_back(RK_EXPIRED);
    for (int i = 0; i < 16; i++) begin
      rows.push_back(build(OP_ADD, DL_W'(1000 + i % 3), 40'(i % 2), '0, '0, 63'd900));
      row_hint.push_back(RK_ANY);
    end
    rows.push_back(build(OP_ADD, '0, '0, '0, '0, '0));           row_hint.push_back(RK_FULL);
    rows.push_back(build(OP_EXPIRE, '0, '0, '0, '0, DL_MAX));    row_hint.push_back(RK_EXPIRED);
    foreach (rows[i]) send_command(rows[i], row_hint[i]);
    drain_and_settle();

    // Several settings of the minimum delay, each followed by a random phase.
    clock_t = 63'd1000;
    sent = 0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_min_delay('0);
        1: write_min_delay('1);
        2: write_min_delay(20'd1);
        3: write_min_delay(MIND_W'($urandom));
        default: write_min_delay(MIN_DELAY_RST);
      endcase
      for (int k = 0; k < 66; k++) begin
        if (phase == 2 && k == 10) long_hold_go = 1'b1;
        random_command(clock_t);
        sent++;
      end
      // Sender waits until everything has come back before the next setting.
      drain_and_settle();
    end

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
